FILE: src/kls_pkg.sv
// ----------------------------------------------------------------------------
// kls_pkg: shared types and constants for the k-th largest selector
// Defaults for the block parameters, field widths, status codes, FSM states
// and the control bundle that the top level broadcasts to the cell row.
// ----------------------------------------------------------------------------
package kls_pkg;

   localparam int MAX_ITEMS_DEF  = 64;
   localparam int SCORE_BITS_DEF = 10;
   localparam int RANK_BITS      = 7;
   localparam int STATUS_BITS    = 2;

   typedef enum logic [STATUS_BITS-1:0] {
      STATUS_OK       = 2'd0,
      STATUS_TOO_FEW  = 2'd1,
      STATUS_OVERFLOW = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ST_LOAD = 2'b01,
      ST_SEEK = 2'b10
   } state_type;

   typedef struct packed {
      logic insert;
      logic shift;
   } cell_ctl_type;

endpackage

FILE: src/kls_if.sv
// ----------------------------------------------------------------------------
// kls_if: stream channels of the k-th largest selector
// Score channel into the block and result channel out of it, each a
// valid/ready pair with its payload.
// ----------------------------------------------------------------------------
interface kls_req_if import kls_pkg::*; #(
   parameter int SCORE_BITS = SCORE_BITS_DEF
) ();
   logic                  valid;
   logic                  ready;
   logic [SCORE_BITS-1:0] score;
   logic                  last_item;

   modport source (output valid, output score, output last_item, input ready);
   modport sink   (input valid, input score, input last_item, output ready);
endinterface

interface kls_rsp_if import kls_pkg::*; #(
   parameter int SCORE_BITS = SCORE_BITS_DEF
) ();
   logic                   valid;
   logic                   ready;
   logic [SCORE_BITS-1:0]  threshold;
   logic [STATUS_BITS-1:0] status;

   modport source (output valid, output threshold, output status, input ready);
   modport sink   (input valid, input threshold, input status, output ready);
endinterface

FILE: src/kls_cell.sv
// ----------------------------------------------------------------------------
// kls_cell: one slot of the sorted insertion row
// Holds one score. On insert it either takes its lower neighbor's score,
// takes the new score, or keeps its own; on shift it takes its upper
// neighbor's score.
// ----------------------------------------------------------------------------
module kls_cell import kls_pkg::*; #(
   parameter int SCORE_BITS = SCORE_BITS_DEF
) (
   input  logic                  clock,
   input  cell_ctl_type          ctl,
   input  logic [SCORE_BITS-1:0] score,
   input  logic                  occupied,
   input  logic [SCORE_BITS-1:0] prev_value,
   input  logic                  prev_greater,
   input  logic [SCORE_BITS-1:0] next_value,
   output logic [SCORE_BITS-1:0] value_out,
   output logic                  greater_out
);

   logic [SCORE_BITS-1:0] value_ff;
   logic [SCORE_BITS-1:0] value_in;

   assign greater_out = occupied && (value_ff > score);
   assign value_out   = value_ff;

   always_comb begin
      value_in = value_ff;
      if (ctl.shift) begin
         value_in = next_value;
      end else if (ctl.insert) begin
         // make room: the lower neighbor is larger, so its score moves up
         if (prev_greater) begin
            value_in = prev_value;
         end else if (greater_out || !occupied) begin
            value_in = score;
         end
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

endmodule

FILE: src/kth_largest_select.sv
// ----------------------------------------------------------------------------
// kth_largest_select: k-th largest score of a loaded set
// Insertion row of cells that keeps the scores in ascending order, with a
// seek pass that shifts the row down to the selected rank.
// ----------------------------------------------------------------------------
// Each score transaction writes the new score into its place in the cell
// row at the clock edge that accepts it. The transaction that carries
// last_item is followed by a seek phase in which no score is accepted: the
// row shifts toward cell 0 once per cycle, n - k times for a set of n scores
// and rank k, and the result register is then loaded as soon as it is free
// (with no shifts when the status is not ok). Scores beyond MAX_ITEMS are
// dropped and the set reports status 2; a rank of 0 or above the number of
// stored scores reports status 1. The result register lets a new set start
// loading while the previous result waits to be taken.
// ----------------------------------------------------------------------------
module kth_largest_select import kls_pkg::*; #(
   parameter int MAX_ITEMS  = MAX_ITEMS_DEF,
   parameter int SCORE_BITS = SCORE_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   kls_req_if.sink              req_ch,
   kls_rsp_if.source            rsp_ch,
   input  logic                 csr_wr_en,
   input  logic [RANK_BITS-1:0] csr_wr_data
);

   localparam int CNT_BITS = $clog2(MAX_ITEMS + 1);
   localparam int CMP_BITS = (RANK_BITS > CNT_BITS) ? RANK_BITS : CNT_BITS;
   localparam logic [CNT_BITS-1:0] FULL_COUNT = CNT_BITS'(MAX_ITEMS);

   state_type             state_ff, state_in;
   logic [CNT_BITS-1:0]   count_ff, count_in;
   logic                  overflow_ff, overflow_in;
   logic [RANK_BITS-1:0]  rank_k_ff;
   logic [CNT_BITS-1:0]   remain_ff, remain_in;
   status_type            status_hold_ff, status_hold_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [SCORE_BITS-1:0] threshold_ff, threshold_in;
   status_type            rsp_status_ff, rsp_status_in;

   cell_ctl_type          cell_ctl;
   logic                  accept;
   logic                  full;
   logic                  out_free;
   logic [CNT_BITS-1:0]   count_next;
   logic [CMP_BITS-1:0]   count_cmp;
   logic [CMP_BITS-1:0]   rank_cmp;
   logic [CMP_BITS-1:0]   sel_index;
   status_type            set_status;

   logic [SCORE_BITS-1:0] cell_value [MAX_ITEMS];
   logic                  cell_greater [MAX_ITEMS];
   logic                  cell_occ [MAX_ITEMS];

   assign req_ch.ready = (state_ff == ST_LOAD);
   assign accept       = req_ch.valid && req_ch.ready;
   assign full         = (count_ff == FULL_COUNT);
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;

   assign cell_ctl.insert = accept && !full;
   assign cell_ctl.shift  = (state_ff == ST_SEEK) && (remain_ff != '0);

   // status of the set as it stands once the closing score is in
   assign count_next = full ? count_ff : count_ff + CNT_BITS'(1);
   assign count_cmp  = CMP_BITS'(count_next);
   assign rank_cmp   = CMP_BITS'(rank_k_ff);
   assign sel_index  = count_cmp - rank_cmp;

   always_comb begin
      priority if (overflow_ff || full) begin
         set_status = STATUS_OVERFLOW;
      end else if (rank_k_ff == '0 || rank_cmp > count_cmp) begin
         set_status = STATUS_TOO_FEW;
      end else begin
         set_status = STATUS_OK;
      end
   end

   for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
      localparam logic [CNT_BITS-1:0] POS = CNT_BITS'(i);
      logic [SCORE_BITS-1:0] prev_value;
      logic                  prev_greater;
      logic [SCORE_BITS-1:0] next_value;

      assign cell_occ[i] = (POS < count_ff);

      if (i == 0) begin : g_first
         assign prev_value   = '0;
         assign prev_greater = 1'b0;
      end else begin : g_inner
         assign prev_value   = cell_value[i-1];
         assign prev_greater = cell_greater[i-1];
      end

      if (i == MAX_ITEMS - 1) begin : g_top
         assign next_value = cell_value[i];
      end else begin : g_below
         assign next_value = cell_value[i+1];
      end

      kls_cell #(
         .SCORE_BITS (SCORE_BITS)
      ) u_cell (
         .clock        (clock),
         .ctl          (cell_ctl),
         .score        (req_ch.score),
         .occupied     (cell_occ[i]),
         .prev_value   (prev_value),
         .prev_greater (prev_greater),
         .next_value   (next_value),
         .value_out    (cell_value[i]),
         .greater_out  (cell_greater[i])
      );
   end

   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      overflow_in    = overflow_ff;
      remain_in      = remain_ff;
      status_hold_in = status_hold_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ch.ready;
      threshold_in   = threshold_ff;
      rsp_status_in  = rsp_status_ff;

      unique case (state_ff)
         ST_LOAD: begin
            if (accept) begin
               count_in    = count_next;
               overflow_in = overflow_ff || full;
               if (req_ch.last_item) begin
                  status_hold_in = set_status;
                  remain_in      = (set_status == STATUS_OK) ?
                                   CNT_BITS'(sel_index) : '0;
                  state_in       = ST_SEEK;
               end
            end
         end
         ST_SEEK: begin
            if (remain_ff != '0) begin
               remain_in = remain_ff - CNT_BITS'(1);
            end else if (out_free) begin
               // cell 0 now holds the selected rank
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_hold_ff;
               threshold_in  = (status_hold_ff == STATUS_OK) ? cell_value[0] : '0;
               count_in      = '0;
               overflow_in   = 1'b0;
               state_in      = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         count_ff     <= '0;
         overflow_ff  <= 1'b0;
         remain_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         rank_k_ff    <= RANK_BITS'(1);
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         overflow_ff  <= overflow_in;
         remain_ff    <= remain_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            rank_k_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      status_hold_ff <= status_hold_in;
      threshold_ff   <= threshold_in;
      rsp_status_ff  <= rsp_status_in;
   end

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.threshold = threshold_ff;
   assign rsp_ch.status    = rsp_status_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_COUNT)
      else $error("score count exceeds store size");

   a_seek_step: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SEEK && remain_ff != '0) |=>
         (state_ff == ST_SEEK && remain_ff == $past(remain_ff) - CNT_BITS'(1)))
      else $error("seek pass did not advance by one");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff != STATUS_OK) |-> (threshold_ff == '0))
      else $error("error result carries a nonzero threshold");

   a_set_cleared: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> (state_ff == ST_LOAD && count_ff == '0 && !overflow_ff))
      else $error("set state not cleared after result");

endmodule
